/* src/block_jacobi_grid_smoother_top_defines.svh */
// Assertion macros shared by the smoother's checker.
// No dependencies; every macro expects signals clk and rst in scope.
`ifndef BLOCK_JACOBI_GRID_SMOOTHER_TOP_DEFINES_SVH
`define BLOCK_JACOBI_GRID_SMOOTHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BJGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BJGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bjgs_pkg.sv */
// Types and constants of the block Jacobi grid smoother.
// Used by the controller, datapath, top level and checker.
package bjgs_pkg;

  localparam int DIM_W = 7;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_SOLVE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_SWEEPS = 2'd0,
    REG_ROWS   = 2'd1,
    REG_COLS   = 2'd2,
    REG_SPARE  = 2'd3
  } reg_index_t;

  localparam logic [3:0]       SWEEPS_RESET = 4'd5;
  localparam logic [DIM_W-1:0] ROWS_RESET   = 7'd64;
  localparam logic [DIM_W-1:0] COLS_RESET   = 7'd64;

  typedef struct packed {
    action_t            action;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SWEEP
  } state_t;

  // Steps of one cell update.
  typedef enum logic [2:0] {
    PH_UP    = 3'd0,
    PH_DOWN  = 3'd1,
    PH_LEFT  = 3'd2,
    PH_RIGHT = 3'd3,
    PH_LAST  = 3'd4,
    PH_WRITE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  typedef enum logic [1:0] {
    OSRC_ITEM,
    OSRC_READ,
    OSRC_ZERO
  } osrc_t;

  typedef struct packed {
    logic  res_wr;
    logic  item_rd;
    logic  solve_done;
    logic  nb_rd;
    dir_t  nb_dir;
    logic  nb_use;
    logic  src_sel;
    logic  acc_load;
    logic  acc_add;
    logic  est_wr;
    logic  out_load;
    osrc_t out_src;
  } cmd_t;

  typedef struct packed {
    action_t          action;
    logic             in_tile;
    logic             out_free;
    logic [3:0]       sweeps;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } sts_t;

endpackage

/* src/block_jacobi_grid_smoother_top.sv */
// Top level of the block Jacobi grid smoother.
// Depends on bjgs_pkg, bjgs_ctl and bjgs_dp.
//
//   Channel   Direction  Handshake            Payload
//   config    in         cfg_we               cfg_index, cfg_data
//   input     in         in_valid / in_stall  in_item (in_item_t)
//   result    out        out_valid / out_stall out_item (out_item_t)
//
// Write and unused-action items are done in ST_IDLE; a read also passes ST_RD_WAIT.
// A solve steps each cell through six phases: four neighbor reads, one at a
// time through the read port of the source estimate buffer, then a sum and a write.
// Reset is synchronous; the memories are not cleared and need no sweep.
// in_stall stays high during a read or solve, and while a result is held.
module block_jacobi_grid_smoother_top import bjgs_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  cmd_t                        cmd;
  sts_t                        sts;
  logic [$clog2(MAX_ROWS)-1:0] cell_row;
  logic [$clog2(MAX_COLS)-1:0] cell_col;

  bjgs_ctl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .cell_row (cell_row),
    .cell_col (cell_col)
  );

  bjgs_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* src/bjgs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bjgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bjgs_ctl.sv */
// Controller of the smoother: item decode and the sweep sequencer.
// Depends on bjgs_pkg; drives the datapath through cmd_t.
module bjgs_ctl import bjgs_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sts_t                        sts,
  output cmd_t                        cmd,
  output logic [$clog2(MAX_ROWS)-1:0] cell_row,
  output logic [$clog2(MAX_COLS)-1:0] cell_col
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CLW  = $clog2(MAX_COLS);
  localparam int MW   = (RW > CLW) ? RW : CLW;
  localparam int CMPW = ((MW > DIM_W) ? MW : DIM_W) + 1;

  state_t         state, state_next;
  phase_t         phase, phase_next;
  logic [RW-1:0]  r, r_next;
  logic [CLW-1:0] c, c_next;
  logic [3:0]     sweep, sweep_next;

  logic has_up, has_down, has_left, has_right, prev_ok;
  logic row_end, col_end, last_sweep;

  assign cell_row = r;
  assign cell_col = c;

  // Neighbor presence and tile position of the current cell.
  always_comb begin
    prev_ok    = (sweep != 4'd0);
    has_up     = (r != '0);
    has_down   = (CMPW'(r) + CMPW'(1)) < CMPW'(sts.rows);
    has_left   = (c != '0);
    has_right  = (CMPW'(c) + CMPW'(1)) < CMPW'(sts.cols);
    row_end    = !has_down;
    col_end    = !has_right;
    last_sweep = (sweep + 4'd1) == sts.sweeps;
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_UP;
      r     <= '0;
      c     <= '0;
      sweep <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      r     <= r_next;
      c     <= c_next;
      sweep <= sweep_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    phase_next = phase;
    r_next     = r;
    c_next     = c;
    sweep_next = sweep;
    cmd        = '0;
    in_stall   = 1'b1;
    cmd.src_sel = sweep[0];

    unique case (state)
      ST_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          unique case (sts.action)
            ACT_WRITE: begin
              cmd.res_wr   = sts.in_tile;
              cmd.out_load = 1'b1;
              cmd.out_src  = OSRC_ITEM;
            end
            ACT_READ: begin
              cmd.item_rd = 1'b1;
              state_next  = ST_RD_WAIT;
            end
            ACT_SOLVE: begin
              if (sts.sweeps == 4'd0) begin
                cmd.solve_done = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.out_src    = OSRC_ZERO;
              end else begin
                state_next = ST_SWEEP;
                phase_next = PH_UP;
                r_next     = '0;
                c_next     = '0;
                sweep_next = '0;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.out_src  = OSRC_ITEM;
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        cmd.out_load = 1'b1;
        cmd.out_src  = OSRC_READ;
        state_next   = ST_IDLE;
      end

      ST_SWEEP: begin
        unique case (phase)
          PH_UP: begin
            cmd.nb_rd  = 1'b1;
            cmd.nb_dir = DIR_UP;
            cmd.nb_use = prev_ok && has_up;
            phase_next = PH_DOWN;
          end
          PH_DOWN: begin
            cmd.nb_rd    = 1'b1;
            cmd.nb_dir   = DIR_DOWN;
            cmd.nb_use   = prev_ok && has_down;
            cmd.acc_load = 1'b1;
            phase_next   = PH_LEFT;
          end
          PH_LEFT: begin
            cmd.nb_rd   = 1'b1;
            cmd.nb_dir  = DIR_LEFT;
            cmd.nb_use  = prev_ok && has_left;
            cmd.acc_add = 1'b1;
            phase_next  = PH_RIGHT;
          end
          PH_RIGHT: begin
            cmd.nb_rd   = 1'b1;
            cmd.nb_dir  = DIR_RIGHT;
            cmd.nb_use  = prev_ok && has_right;
            cmd.acc_add = 1'b1;
            phase_next  = PH_LAST;
          end
          PH_LAST: begin
            cmd.acc_add = 1'b1;
            phase_next  = PH_WRITE;
          end
          PH_WRITE: begin
            cmd.est_wr = 1'b1;
            phase_next = PH_UP;
            if (!col_end) begin
              c_next = c + CLW'(1);
            end else begin
              c_next = '0;
              if (!row_end) begin
                r_next = r + RW'(1);
              end else begin
                r_next = '0;
                if (last_sweep) begin
                  cmd.solve_done = 1'b1;
                  cmd.out_load   = 1'b1;
                  cmd.out_src    = OSRC_ZERO;
                  state_next     = ST_IDLE;
                end else begin
                  sweep_next = sweep + 4'd1;
                end
              end
            end
          end
          default: begin
            phase_next = PH_UP;
          end
        endcase
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/bjgs_dp.sv */
// Datapath of the smoother: registers, memories, accumulator, result register.
// Depends on bjgs_pkg and bjgs_ram; controlled through cmd_t.
module bjgs_dp import bjgs_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [DIM_W-1:0]            cfg_data,
  input  in_item_t                    in_item,
  input  cmd_t                        cmd,
  input  logic [$clog2(MAX_ROWS)-1:0] cell_row,
  input  logic [$clog2(MAX_COLS)-1:0] cell_col,
  output sts_t                        sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output out_item_t                   out_item
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CLW   = $clog2(MAX_COLS);
  localparam int AW    = RW + CLW;
  localparam int DEPTH = 1 << AW;

  logic [3:0]       cfg_sweeps;
  logic [DIM_W-1:0] cfg_rows, cfg_cols;
  logic [DIM_W-1:0] rows, cols;

  logic             solved, sol_zero, fin_sel;
  logic [DIM_W-1:0] sol_rows, sol_cols;
  logic             rd_ok, rd_stat, rd_sel, nb_use_q;

  logic [AW-1:0] item_addr, cell_addr, nb_addr, est_raddr;
  logic [RW-1:0] nb_row;
  logic [CLW-1:0] nb_col;
  logic [31:0]   res_rdata, e0_rdata, e1_rdata, est_rdata;
  logic          cell_in_tile, in_sol_tile;

  logic signed [34:0] acc, nb_term;
  logic signed [32:0] quarter;
  logic [31:0]        est_wdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sweeps <= SWEEPS_RESET;
      cfg_rows   <= ROWS_RESET;
      cfg_cols   <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWEEPS: cfg_sweeps <= cfg_data[3:0];
        REG_ROWS:   cfg_rows   <= cfg_data;
        REG_COLS:   cfg_cols   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Effective tile size: zero acts as one, and the size tops out at the maximum.
  always_comb begin
    if (cfg_rows == '0) begin
      rows = DIM_W'(1);
    end else if (32'(cfg_rows) > MAX_ROWS) begin
      rows = DIM_W'(MAX_ROWS);
    end else begin
      rows = cfg_rows;
    end
    if (cfg_cols == '0) begin
      cols = DIM_W'(1);
    end else if (32'(cfg_cols) > MAX_COLS) begin
      cols = DIM_W'(MAX_COLS);
    end else begin
      cols = cfg_cols;
    end
  end

  // Item decode and status to the controller.
  always_comb begin
    cell_in_tile = ({1'b0, in_item.row} < rows) && ({1'b0, in_item.col} < cols);
    in_sol_tile  = ({1'b0, in_item.row} < sol_rows) && ({1'b0, in_item.col} < sol_cols);
    item_addr    = {RW'(in_item.row), CLW'(in_item.col)};
    cell_addr    = {cell_row, cell_col};

    sts.action   = in_item.action;
    sts.in_tile  = cell_in_tile;
    sts.out_free = !out_valid || !out_stall;
    sts.sweeps   = cfg_sweeps;
    sts.rows     = rows;
    sts.cols     = cols;
  end

  // Neighbor address of the current cell.
  always_comb begin
    nb_row = cell_row;
    nb_col = cell_col;
    case (cmd.nb_dir)
      DIR_UP:    nb_row = cell_row - RW'(1);
      DIR_DOWN:  nb_row = cell_row + RW'(1);
      DIR_LEFT:  nb_col = cell_col - CLW'(1);
      default:   nb_col = cell_col + CLW'(1);
    endcase
    nb_addr   = {nb_row, nb_col};
    est_raddr = cmd.nb_rd ? nb_addr : item_addr;
  end

  bjgs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_res (
    .clk   (clk),
    .we    (cmd.res_wr),
    .waddr (item_addr),
    .wdata (in_item.value),
    .raddr (cell_addr),
    .rdata (res_rdata)
  );

  // Two estimate buffers in ping-pong: a sweep reads one and writes the other.
  bjgs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_est0 (
    .clk   (clk),
    .we    (cmd.est_wr && cmd.src_sel),
    .waddr (cell_addr),
    .wdata (est_wdata),
    .raddr (est_raddr),
    .rdata (e0_rdata)
  );

  bjgs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_est1 (
    .clk   (clk),
    .we    (cmd.est_wr && !cmd.src_sel),
    .waddr (cell_addr),
    .wdata (est_wdata),
    .raddr (est_raddr),
    .rdata (e1_rdata)
  );

  assign est_rdata = rd_sel ? e1_rdata : e0_rdata;

  // Read-side tags that travel with the registered read data.
  always_ff @(posedge clk) begin
    rd_sel   <= cmd.nb_rd ? cmd.src_sel : fin_sel;
    nb_use_q <= cmd.nb_use;
    if (cmd.item_rd) begin
      rd_ok   <= cell_in_tile && solved && !sol_zero && in_sol_tile;
      rd_stat <= !cell_in_tile;
    end
  end

  // Five-term sum; the residual enters with the first neighbor.
  always_comb begin
    nb_term = nb_use_q ? 35'(signed'(est_rdata)) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc <= 35'(signed'(res_rdata)) + nb_term;
    end else if (cmd.acc_add) begin
      acc <= acc + nb_term;
    end
  end

  // Divide by four rounding down, then saturate to 32 bits.
  always_comb begin
    quarter = acc[34:2];
    if (!quarter[32] && quarter[31]) begin
      est_wdata = 32'h7fff_ffff;
    end else if (quarter[32] && !quarter[31]) begin
      est_wdata = 32'h8000_0000;
    end else begin
      est_wdata = quarter[31:0];
    end
  end

  // Record of the last solve, which decides what reads return.
  always_ff @(posedge clk) begin
    if (rst) begin
      solved <= 1'b0;
    end else if (cmd.solve_done) begin
      solved <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.solve_done) begin
      sol_rows <= rows;
      sol_cols <= cols;
      sol_zero <= (cfg_sweeps == 4'd0);
      fin_sel  <= cfg_sweeps[0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_src)
        OSRC_ITEM: begin
          out_item.data   <= '0;
          out_item.status <= (in_item.action == ACT_WRITE) && !cell_in_tile;
        end
        OSRC_READ: begin
          out_item.data   <= rd_ok ? est_rdata : '0;
          out_item.status <= rd_stat;
        end
        default: begin
          out_item.data   <= '0;
          out_item.status <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* src/bjgs_checker.sv */
// Port-level checks of the smoother, bound to the top level.
// Depends on bjgs_pkg and the assertion macro header.
`include "block_jacobi_grid_smoother_top_defines.svh"

module bjgs_checker import bjgs_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A flagged result never carries data.
  `BJGS_ASSERT_NOW(a_status_no_data, out_valid && out_item.status, out_item.data == 32'sd0, "flagged result carries data")

  // A held result stays put.
  `BJGS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "held result changed")

  // A write gives its result in the next cycle.
  `BJGS_ASSERT_NEXT(a_write_result, in_valid && !in_stall && in_item.action == ACT_WRITE, out_valid, "write gave no result")

  // A read waits for the registered memory data, so no item is taken right after it.
  `BJGS_ASSERT_NEXT(a_read_blocks, in_valid && !in_stall && in_item.action == ACT_READ, in_stall, "item taken during read")

endmodule

bind block_jacobi_grid_smoother_top bjgs_checker u_bjgs_checker (.*);
